// ===== src/rmsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsm_pkg
// Shared widths, constants and request types for the windowed rms level meter.
// ----------------------------------------------------------------------------
package rmsm_pkg;

    localparam int SMP_W      = 16;
    localparam int SUM_W      = 48;
    localparam int SQ_W       = 32;
    localparam int MEAN_W     = 32;
    localparam int ROOT_W     = 16;
    localparam int REM_W      = 18;
    localparam int ALU_W      = 20;
    localparam int DIV_STEPS  = 48;
    localparam int SQRT_STEPS = 16;
    localparam int STEP_W     = 6;

    localparam logic [SMP_W-1:0] DEFAULT_WINDOW = 16'd8000;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [SMP_W-1:0] divisor;
    } t_root_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_root_rsp;

endpackage

`default_nettype wire

// ===== src/rmsm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsm_if
// Valid/ready channels of the rms level meter: samples, results, window length.
// ----------------------------------------------------------------------------
interface rmsm_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rmsm_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] rms_level;
    logic [15:0] window_count;

    modport source (output valid, output rms_level, output window_count, input ready);
    modport sink   (input valid, input rms_level, input window_count, output ready);
endinterface

interface rmsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

// ===== src/rmsm_root.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsm_root
// Iterative mean and square root: restoring divide of the square sum by the
// count, then digit-by-digit root, both through one shared subtractor.
// ----------------------------------------------------------------------------
module rmsm_root (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rmsm_pkg::t_root_req i_req,
    output rmsm_pkg::t_root_rsp o_rsp
);
    import rmsm_pkg::*;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_DIV  = 2'd1;
    localparam logic [1:0] P_SQRT = 2'd2;

    logic [1:0]        r_phase, n_phase;
    logic              r_done,  n_done;
    logic [SUM_W-1:0]  r_work,  n_work;
    logic [REM_W-1:0]  r_rem,   n_rem;
    logic [ROOT_W-1:0] r_root,  n_root;
    logic [SMP_W-1:0]  r_div,   n_div;
    logic [STEP_W-1:0] r_step,  n_step;

    logic [ALU_W-1:0]  alu_a;
    logic [ALU_W-1:0]  alu_b;
    logic [ALU_W-1:0]  alu_diff;
    logic              alu_borrow;
    logic              alu_ge;

    // shared subtractor operands
    always_comb begin
        if (r_phase == P_SQRT) begin
            alu_a = {r_rem, r_work[MEAN_W-1 -: 2]};
            alu_b = {{(ALU_W-ROOT_W-2){1'b0}}, r_root, 2'b01};
        end else begin
            alu_a = {{(ALU_W-SMP_W-1){1'b0}}, r_rem[SMP_W-1:0], r_work[SUM_W-1]};
            alu_b = {{(ALU_W-SMP_W){1'b0}}, r_div};
        end
    end

    assign {alu_borrow, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge = ~alu_borrow;

    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        n_work  = r_work;
        n_rem   = r_rem;
        n_root  = r_root;
        n_div   = r_div;
        n_step  = r_step;
        case (r_phase)
            P_IDLE: begin
                if (i_req.start) begin
                    n_work  = i_req.sum;
                    n_div   = i_req.divisor;
                    n_rem   = '0;
                    n_step  = '0;
                    n_phase = P_DIV;
                end
            end
            P_DIV: begin
                n_work = {r_work[SUM_W-2:0], alu_ge};
                n_rem  = alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_rem   = '0;
                    n_root  = '0;
                    n_phase = P_SQRT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            P_SQRT: begin
                n_work = {r_work[SUM_W-3:0], 2'b00};
                n_rem  = alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
                n_root = {r_root[ROOT_W-2:0], alu_ge};
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_step  = '0;
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_div  <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

`default_nettype wire

// ===== src/windowed_rms_level_meter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_rms_level_meter
// Squares Q1.15 samples into a 48-bit sum and reports the floored root of the
// window mean, with the sample count, when the window length is reached.
// ----------------------------------------------------------------------------
//  port     dir  payload                     meaning
//  i_smp    in   sample                      one audio sample per request
//  o_res    out  rms_level, window_count     one result per closed window
//  i_cfg    in   window_length               window length, zero means 8000
//
//  a sample is taken in steps: accept, square, accumulate
//  a window-closing sample then runs 48 divide and 16 root steps through
//  one 20-bit subtractor, then a done hand-off and the result load
//  i_rst_n is synchronous; window length resets to 8000, sum and count to zero
//  a result waits in the output register; a new sample is taken meanwhile,
//  but the next closing window holds until that register is free
// ----------------------------------------------------------------------------
module windowed_rms_level_meter (
    input  wire               i_clk,
    input  wire               i_rst_n,
    rmsm_smp_if.sink          i_smp,
    rmsm_res_if.source        o_res,
    rmsm_cfg_if.sink          i_cfg
);
    import rmsm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQR  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [SMP_W-1:0]  r_wlen;
    logic [SUM_W-1:0]  r_sum,   n_sum;
    logic [SMP_W-1:0]  r_cnt,   n_cnt;
    logic [SMP_W-1:0]  r_mag;
    logic [SQ_W-1:0]   r_sq;
    logic [SMP_W-1:0]  r_wcnt,  n_wcnt;
    logic              r_ovalid, n_ovalid;
    logic [ROOT_W-1:0] r_orms,  n_orms;
    logic [SMP_W-1:0]  r_ocnt,  n_ocnt;

    logic [SMP_W-1:0]  smp_mag;
    logic [SUM_W-1:0]  acc_sum;
    logic [SMP_W-1:0]  acc_cnt;
    logic [SMP_W-1:0]  win;
    logic              smp_req;
    t_root_req         root_req;
    t_root_rsp         root_rsp;

    rmsm_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (root_req),
        .o_rsp   (root_rsp)
    );

    assign i_smp.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign smp_req     = i_smp.valid && i_smp.ready;

    assign smp_mag = i_smp.sample[SMP_W-1] ? (~i_smp.sample + 1'b1) : i_smp.sample;
    assign acc_sum = r_sum + {{(SUM_W-SQ_W){1'b0}}, r_sq};
    assign acc_cnt = r_cnt + 1'b1;
    assign win     = (r_wlen == '0) ? DEFAULT_WINDOW : r_wlen;

    always_comb begin
        n_state  = r_state;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_wcnt   = r_wcnt;
        n_ovalid = r_ovalid && !o_res.ready;
        n_orms   = r_orms;
        n_ocnt   = r_ocnt;
        root_req = '{start: 1'b0, sum: acc_sum, divisor: acc_cnt};
        case (r_state)
            S_IDLE: begin
                if (smp_req) begin
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (acc_cnt >= win) begin
                    root_req.start = 1'b1;
                    n_wcnt  = acc_cnt;
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_state = S_ROOT;
                end else begin
                    n_sum   = acc_sum;
                    n_cnt   = acc_cnt;
                    n_state = S_IDLE;
                end
            end
            S_ROOT: begin
                if (root_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!n_ovalid) begin
                    n_ovalid = 1'b1;
                    n_orms   = root_rsp.root;
                    n_ocnt   = r_wcnt;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wlen   <= DEFAULT_WINDOW;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_wlen <= i_cfg.window_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (smp_req) begin
            r_mag <= smp_mag;
        end
        r_sq   <= r_mag * r_mag;
        r_wcnt <= n_wcnt;
        r_orms <= n_orms;
        r_ocnt <= n_ocnt;
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.rms_level    = r_orms;
    assign o_res.window_count = r_ocnt;

`ifndef SYNTHESIS
    a_req_to_sqr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_req |=> (r_state == S_SQR))
        else $error("accepted sample did not start squaring");

    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) && root_rsp.done |=> (r_state == S_OUT))
        else $error("root result not handed to output stage");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.rms_level <= 16'd32768))
        else $error("rms level above full scale");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.window_count != '0))
        else $error("result with empty window");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt != '1))
        else $error("sample count at limit while idle");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed rms level meter testbench
// Streams Q1.15 samples through the meter under many window lengths. Both
// channels stall at random. A scoreboard squares and sums each sample, and
// works out every window's floored root mean square and count. Each result
// the meter returns is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module testbench;
    import rmsm_pkg::*;

    localparam int GAP_PCT        = 28;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_ITEMS   = 900;
    localparam int SHORT_WIN_MAX  = 40;

    localparam logic [SMP_W-1:0] FULL_NEG = 16'h8000;
    localparam logic [SMP_W-1:0] FULL_POS = 16'h7FFF;

    typedef struct packed {
        logic [15:0] level;
        logic [15:0] count;
    } t_window_result;

    class rms_scoreboard;
        logic [15:0]      win_len;
        logic [SUM_W-1:0] acc_sum;
        logic [15:0]      acc_count;
        t_window_result   expected_windows[$];
        int               errors;

        function new();
            win_len   = DEFAULT_WINDOW;
            acc_sum   = '0;
            acc_count = '0;
            errors    = 0;
        endfunction

        function logic [15:0] floor_root(logic [SUM_W-1:0] v);
            logic [SUM_W-1:0] root;
            logic [SUM_W-1:0] trial;
            root = '0;
            for (int b = 15; b >= 0; b--) begin
                trial = root | (48'd1 << b);
                if (trial * trial <= v) begin
                    root = trial;
                end
            end
            return root[15:0];
        endfunction

        function void set_window(logic [15:0] value);
            win_len = value;
        endfunction

        function void note_sample(logic [15:0] raw);
            logic [15:0]    mag;
            logic [31:0]    square;
            logic [15:0]    limit;
            t_window_result r;
            mag       = raw[15] ? (~raw + 16'd1) : raw;
            square    = {16'd0, mag} * {16'd0, mag};
            acc_sum   = acc_sum + {16'd0, square};
            acc_count = acc_count + 16'd1;
            limit     = (win_len == 16'd0) ? DEFAULT_WINDOW : win_len;
            if (acc_count >= limit) begin
                r.level = floor_root(acc_sum / {32'd0, acc_count});
                r.count = acc_count;
                expected_windows.push_back(r);
                acc_sum   = '0;
                acc_count = '0;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_result(logic [15:0] level, logic [15:0] count);
            t_window_result want;
            if (expected_windows.size() == 0) begin
                report($sformatf("unexpected result level %0d count %0d", level, count));
            end else begin
                want = expected_windows.pop_front();
                if (level !== want.level) begin
                    report($sformatf("rms_level %0d, want %0d", level, want.level));
                end
                if (count !== want.count) begin
                    report($sformatf("window_count %0d, want %0d", count, want.count));
                end
            end
        endtask

        function int pending();
            return expected_windows.size();
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          gaps_on;
    int unsigned   idle_cycles = 0;
    rms_scoreboard sb;

    rmsm_smp_if smp_ch ();
    rmsm_res_if res_ch ();
    rmsm_cfg_if cfg_ch ();

    windowed_rms_level_meter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.set_window(cfg_ch.window_length);
            end
            if (smp_ch.valid && smp_ch.ready) begin
                sb.note_sample(smp_ch.sample);
            end
            if (res_ch.valid && res_ch.ready) begin
                sb.check_result(res_ch.rms_level, res_ch.window_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    function automatic logic [15:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 4))
                0:       return FULL_NEG;
                1:       return FULL_POS;
                2:       return 16'h0000;
                3:       return 16'h0001;
                default: return 16'hFFFF;
            endcase
        end else if (roll < 25) begin
            return {16{roll[0]}} ^ 16'($urandom_range(0, 255));
        end
        return 16'($urandom);
    endfunction

    task automatic send_sample(input logic [15:0] value);
        while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
            smp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= value;
        @(posedge i_clk);
        while (!smp_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        smp_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_window(input logic [15:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.window_length <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int          sent;
        int          n;
        int unsigned roll;
        logic [15:0] w;

        sb                   = new();
        gaps_on              = 1'b1;
        i_rst_n             <= 1'b0;
        smp_ch.valid        <= 1'b0;
        smp_ch.sample       <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.window_length <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default window, nothing closes
        send_sample(FULL_POS);
        send_sample(FULL_NEG);
        send_sample(16'h0000);
        // zero window behaves as the default
        write_window(16'd0);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        write_window(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        // window shortened below the running count
        write_window(16'd2);
        send_sample(FULL_NEG);
        write_window(16'd1);
        send_sample(FULL_NEG);
        send_sample(FULL_POS);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        write_window(16'd2);
        send_sample(FULL_NEG);
        send_sample(FULL_NEG);
        write_window(16'd3);
        send_sample(FULL_POS);
        send_sample(FULL_NEG);
        send_sample(16'h0000);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                w = 16'd1;
            end else if (roll < 70) begin
                w = 16'($urandom_range(2, 8));
            end else if (roll < 88) begin
                w = 16'($urandom_range(9, SHORT_WIN_MAX));
            end else if (roll < 92) begin
                w = 16'd0;
            end else if (roll < 96) begin
                w = 16'hFFFF;
            end else begin
                w = 16'($urandom_range(SHORT_WIN_MAX + 1, 65534));
            end
            write_window(w);
            if (w == 16'd0 || w > SHORT_WIN_MAX) begin
                n = $urandom_range(1, 30);
            end else begin
                n = $urandom_range(1, 5 * int'(w));
            end
            for (int i = 0; i < n; i++) begin
                gaps_on = !(sent >= 300 && sent < 450);
                send_sample(pick_sample());
                sent++;
            end
        end
        gaps_on = 1'b1;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
